>>> design/rbwpp_pkg.sv
// Shared constants, register indexes and arithmetic helpers for the RGBA to packed pixel converter.
package rbwpp_pkg;

	localparam int unsigned NUM_CH = 3;

	typedef enum logic [1:0] {
		REG_RED_MASK   = 2'd0,
		REG_GREEN_MASK = 2'd1,
		REG_BLUE_MASK  = 2'd2,
		REG_DEPTH      = 2'd3
	} cfg_reg_t;

	localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;
	localparam logic [5:0]  DEPTH_RST      = 6'd24;

	// position and run length that the reset masks decode to
	localparam logic [4:0] RED_POS_RST   = 5'd16;
	localparam logic [4:0] GREEN_POS_RST = 5'd8;
	localparam logic [4:0] BLUE_POS_RST  = 5'd0;
	localparam logic [5:0] CH_LEN_RST    = 6'd8;

	localparam logic [5:0] DEPTH_NARROW_MIN = 6'd9;
	localparam logic [5:0] DEPTH_WIDE_MIN   = 6'd17;

	localparam logic [5:0] REP_BITS = 6'd40;

	// count of trailing zeros, 32 for an all-zero word
	function automatic logic [5:0] ctz32(input logic [31:0] v);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) n = 6'(i);
		end
		return n;
	endfunction

	// floor(x/255), exact for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + 17'd1 + 17'(x[15:8]);
		return s[15:8];
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] c, input logic [2:0] k);
		logic [15:0] t;
		t = {c, c} << k;
		return t[15:8];
	endfunction

endpackage

>>> design/rgba_blend_white_pixel_packer.sv
// RGBA pixel blended onto white, rescaled per channel mask and packed into a display word.
// Pipeline: 4 register stages; each moves on when the stage after it is empty or moving.
// Throughput: one pixel per cycle, held back only by result_stall.
// Reset: masks and depth return to their defaults (0xFF0000, 0xFF00, 0xFF, 24), pipeline empties.
// Mask position is decoded from the mask registers into pos_q, then the width from it into len_q.
module rgba_blend_white_pixel_packer
	import rbwpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  alpha_in,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] packed_pixel,
	output logic        wide_format,
	output logic        unsupported_depth
);

	// configuration and decoded mask fields
	logic [31:0] mask_q [NUM_CH];
	logic [5:0]  depth_q;
	logic [4:0]  pos_q  [NUM_CH];
	logic [5:0]  len_q  [NUM_CH];
	logic [5:0]  pos_full [NUM_CH];
	logic [5:0]  len_next [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q[0] <= RED_MASK_RST;
			mask_q[1] <= GREEN_MASK_RST;
			mask_q[2] <= BLUE_MASK_RST;
			depth_q   <= DEPTH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RED_MASK:   mask_q[0] <= cfg_data;
				REG_GREEN_MASK: mask_q[1] <= cfg_data;
				REG_BLUE_MASK:  mask_q[2] <= cfg_data;
				REG_DEPTH:      depth_q   <= cfg_data[5:0];
			endcase
		end
	end

	// lowest run of ones: its start, then its length from there
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			pos_full[i] = ctz32(mask_q[i]);
			len_next[i] = ctz32(~(mask_q[i] >> pos_q[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[0] <= RED_POS_RST;
			pos_q[1] <= GREEN_POS_RST;
			pos_q[2] <= BLUE_POS_RST;
			for (int i = 0; i < NUM_CH; i++) len_q[i] <= CH_LEN_RST;
		end else begin
			for (int i = 0; i < NUM_CH; i++) begin
				pos_q[i] <= pos_full[i][4:0];
				len_q[i] <= len_next[i];
			end
		end
	end

	// pipeline flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4      = !valid_s4 || !result_stall;
	assign adv_s3      = !valid_s3 || adv_s4;
	assign adv_s2      = !valid_s2 || adv_s3;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign pixel_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= pixel_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: blend numerator c*a + 255*(255-a)
	logic [7:0]  chan_in [NUM_CH];
	logic [15:0] num_next [NUM_CH];
	logic [7:0]  inv_a;
	logic [15:0] bg_term;

	assign chan_in[0] = red_in;
	assign chan_in[1] = green_in;
	assign chan_in[2] = blue_in;
	assign inv_a      = 8'd255 - alpha_in;
	assign bg_term    = {inv_a, 8'd0} - {8'd0, inv_a};

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			num_next[i] = ({8'd0, chan_in[i]} * {8'd0, alpha_in}) + bg_term;
		end
	end

	logic [15:0] num_s1 [NUM_CH];
	logic [7:0]  chan_s1 [NUM_CH];
	logic        opaque_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < NUM_CH; i++) begin
				num_s1[i]  <= num_next[i];
				chan_s1[i] <= chan_in[i];
			end
			opaque_s1 <= (alpha_in == 8'd255);
		end
	end

	// stage 2: divide by 255, or pass the channel through for an opaque pixel
	logic [7:0] chan_s2 [NUM_CH];

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int i = 0; i < NUM_CH; i++) begin
				chan_s2[i] <= opaque_s1 ? chan_s1[i] : div255(num_s1[i]);
			end
		end
	end

	// stage 3: c*(2^L-1)/255 as the top L bits of c repeated, less one when the
	// fraction left over is smaller than c/255 (c rotated by L mod 8 below c)
	logic [39:0] rep_val  [NUM_CH];
	logic [39:0] top_bits [NUM_CH];
	logic [5:0]  rsh      [NUM_CH];
	logic        borrow   [NUM_CH];
	logic [31:0] scaled_next [NUM_CH];
	logic [31:0] scaled_s3 [NUM_CH];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			rep_val[i]     = {5{chan_s2[i]}};
			rsh[i]         = REP_BITS - len_q[i];
			top_bits[i]    = rep_val[i] >> rsh[i];
			borrow[i]      = (chan_s2[i] != 8'd255)
			              && (rotl8(chan_s2[i], len_q[i][2:0]) < chan_s2[i]);
			scaled_next[i] = top_bits[i][31:0] - {31'd0, borrow[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			for (int i = 0; i < NUM_CH; i++) scaled_s3[i] <= scaled_next[i];
		end
	end

	// stage 4: place channels and select the word format, or blank the word for an unsupported depth
	logic [31:0] pixel_word;
	logic        depth_wide;
	logic        depth_none;

	assign pixel_word = (scaled_s3[0] << pos_q[0])
	                  | (scaled_s3[1] << pos_q[1])
	                  | (scaled_s3[2] << pos_q[2]);
	assign depth_wide = (depth_q >= DEPTH_WIDE_MIN);
	assign depth_none = (depth_q < DEPTH_NARROW_MIN);

	logic [31:0] pixel_s4;
	logic        wide_s4;
	logic        unsup_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			unsup_s4 <= depth_none;
			wide_s4  <= depth_wide;
			priority if (depth_none) pixel_s4 <= 32'd0;
			else if (depth_wide)     pixel_s4 <= pixel_word;
			else                     pixel_s4 <= {16'd0, pixel_word[15:0]};
		end
	end

	assign result_valid      = valid_s4;
	assign packed_pixel      = pixel_s4;
	assign wide_format       = wide_s4;
	assign unsupported_depth = unsup_s4;

`ifndef SYNTHESIS
	a_unsup_blank: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && unsupported_depth |-> packed_pixel == 32'd0 && !wide_format)
		else $error("unsupported depth beat carries a pixel");

	a_narrow_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !wide_format |-> packed_pixel[31:16] == 16'd0)
		else $error("narrow beat has upper half set");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && result_stall)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> verif/tb_rgba_blend_white_pixel_packer.sv
// Self-checking testbench for the RGBA blend-onto-white pixel packer.
module tb_rgba_blend_white_pixel_packer;
	import rbwpp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NDIR            = 31;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int LAT_PAD         = 6;
	localparam int WATCHDOG_LIMIT  = 2000;

	typedef struct packed {
		logic [31:0] word;
		logic        wide;
		logic        unsup;
	} pix_result_t;

	typedef struct packed {
		bit          is_reg;
		cfg_reg_t    idx;
		logic [31:0] data;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		bit          typed;
		pix_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	cfg_reg_t    cfg_index = REG_RED_MASK;
	logic [31:0] cfg_data = '0;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [7:0]  red_in = '0;
	logic [7:0]  green_in = '0;
	logic [7:0]  blue_in = '0;
	logic [7:0]  alpha_in = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [31:0] packed_pixel;
	logic        wide_format;
	logic        unsupported_depth;

	// shadow of the block's registers
	logic [31:0] mask_cfg [3];
	logic [5:0]  depth_cfg;

	pix_result_t pending_pixels [$];
	pix_result_t oldest;
	int          errors = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	bit          idle_on = 1'b1;

	dir_row_t directed_rows [NDIR] = '{
		// reset masks, 8:8:8 wide
		'{1'b0, REG_RED_MASK, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{32'h00FF_FFFF, 1'b1, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{32'h00FF_FFFF, 1'b1, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h12, 8'h34, 8'h56, 8'hFF, 1'b1, '{32'h0012_3456, 1'b1, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h80, 8'h40, 8'h20, 8'h80, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'hAA, 8'h55, 8'hAA, 8'h54, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h01, 8'hFE, 8'h7F, 8'h01, 1'b0, '{32'h0, 1'b0, 1'b0}},
		// unsupported depths
		'{1'b1, REG_DEPTH, 32'd8, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1, '{32'h0, 1'b0, 1'b1}},
		'{1'b1, REG_DEPTH, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{32'h0, 1'b0, 1'b1}},
		// 5:6:5 narrow
		'{1'b1, REG_RED_MASK, 32'hF800, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_GREEN_MASK, 32'h07E0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_BLUE_MASK, 32'h001F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_DEPTH, 32'd16, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{32'h0000_FFFF, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'hC8, 8'h64, 8'h32, 8'h4D, 1'b0, '{32'h0, 1'b0, 1'b0}},
		// red placed above bit 15 is cut off in the narrow word
		'{1'b1, REG_DEPTH, 32'd9, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_RED_MASK, 32'hFFFF_0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
		// zero mask, broken mask, full-width mask, depth beyond 32
		'{1'b1, REG_RED_MASK, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_GREEN_MASK, 32'h0F0F_0F00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_BLUE_MASK, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_DEPTH, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h4D, 8'h80, 8'h01, 8'hC8, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_RED_MASK, 32'h8000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_DEPTH, 32'd17, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'hFF, 8'h80, 8'h7F, 8'hFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b1, REG_DEPTH, 32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{1'b0, REG_RED_MASK, 32'h0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, '{32'h0, 1'b0, 1'b1}}
	};

	rgba_blend_white_pixel_packer u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.pixel_valid       (pixel_valid),
		.pixel_stall       (pixel_stall),
		.red_in            (red_in),
		.green_in          (green_in),
		.blue_in           (blue_in),
		.alpha_in          (alpha_in),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.packed_pixel      (packed_pixel),
		.wide_format       (wide_format),
		.unsupported_depth (unsupported_depth)
	);

	always #5 clk = ~clk;

	// only the lowest run of ones in the mask counts
	function automatic logic [31:0] scale_and_place(input logic [7:0] c, input logic [31:0] m);
		int unsigned lo;
		int unsigned run;
		logic [63:0] full;
		logic [63:0] v;
		lo = 0;
		run = 0;
		if (m == '0)
			return '0;
		while (!m[lo])
			lo++;
		while (lo + run < 32 && m[lo + run])
			run++;
		full = (64'd1 << run) - 64'd1;
		v = (64'(c) * full) / 64'd255;
		return 32'(v << lo);
	endfunction

	function automatic pix_result_t blend_and_pack(input logic [7:0] r, g, b, a);
		pix_result_t res;
		logic [7:0]  ch [3];
		logic [31:0] word;
		res = '0;
		if (depth_cfg < DEPTH_NARROW_MIN) begin
			res.unsup = 1'b1;
			return res;
		end
		ch[0] = r;
		ch[1] = g;
		ch[2] = b;
		word = '0;
		for (int k = 0; k < 3; k++) begin
			if (a != 8'hFF)
				ch[k] = 8'((32'(ch[k]) * a + 32'd255 * (32'd255 - a)) / 32'd255);
			word |= scale_and_place(ch[k], mask_cfg[k]);
		end
		res.wide = (depth_cfg >= DEPTH_WIDE_MIN);
		res.word = res.wide ? word : {16'h0, word[15:0]};
		return res;
	endfunction

	// block drained and mask decode settled on both sides of the write
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		pixel_valid <= 1'b0;
		wait (pending_pixels.size() == 0);
		repeat (LAT_PAD) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_DEPTH)
			depth_cfg = data[5:0];
		else
			mask_cfg[idx] = data;
		repeat (LAT_PAD) @(negedge clk);
	endtask

	// called and returns at a falling edge
	task automatic send_pixel(input logic [7:0] r, g, b, a, input pix_result_t want);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		alpha_in <= a;
		pixel_valid <= 1'b1;
		do
			@(posedge clk);
		while (pixel_stall);
		pending_pixels.push_back(want);
		@(negedge clk);
	endtask

	task automatic field_check(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp, act);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		if (!idle_on) begin
			result_stall <= 1'b0;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			result_stall <= 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected beat, got %h", $time, packed_pixel);
				errors++;
			end else begin
				oldest = pending_pixels.pop_front();
				field_check("packed_pixel", oldest.word, packed_pixel);
				field_check("wide_format", 32'(oldest.wide), 32'(wide_format));
				field_check("unsupported_depth", 32'(oldest.unsup), 32'(unsupported_depth));
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		pix_result_t want;
		logic [5:0]  dep;
		logic [31:0] m;
		logic [7:0]  px [4];
		int unsigned len;
		int unsigned pos;
		int unsigned span;
		mask_cfg[REG_RED_MASK] = RED_MASK_RST;
		mask_cfg[REG_GREEN_MASK] = GREEN_MASK_RST;
		mask_cfg[REG_BLUE_MASK] = BLUE_MASK_RST;
		depth_cfg = DEPTH_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg) begin
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				want = directed_rows[i].typed ? directed_rows[i].want :
					blend_and_pack(directed_rows[i].r, directed_rows[i].g,
						directed_rows[i].b, directed_rows[i].a);
				send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
					directed_rows[i].a, want);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0:       dep = 6'($urandom_range(0, 8));
				1, 2:    dep = 6'($urandom_range(9, 16));
				3:       dep = 6'($urandom_range(33, 63));
				default: dep = 6'($urandom_range(17, 32));
			endcase
			if (p == NUM_PHASES - 1)
				dep = 6'd32;
			write_reg(REG_DEPTH, {26'($urandom), dep});
			// narrow words keep their channels in the low half mostly
			span = (dep >= DEPTH_NARROW_MIN && dep < DEPTH_WIDE_MIN) ? 16 : 32;
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 9))
					0: m = '0;
					1: m = '1;
					2: m = $urandom;
					default: begin
						len = $urandom_range(1, span);
						pos = $urandom_range(0, span - len);
						m = 32'(((64'd1 << len) - 64'd1) << pos);
					end
				endcase
				write_reg(cfg_reg_t'(k), m);
			end
			idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			repeat (ITEMS_PER_PHASE) begin
				for (int k = 0; k < 4; k++) begin
					case ($urandom_range(0, 7))
						0:       px[k] = 8'h00;
						1:       px[k] = 8'hFF;
						default: px[k] = 8'($urandom_range(0, 255));
					endcase
				end
				// favour opaque and fully transparent pixels a little
				case ($urandom_range(0, 7))
					0, 1:    px[3] = 8'hFF;
					2:       px[3] = 8'h00;
					default: ;
				endcase
				send_pixel(px[0], px[1], px[2], px[3], blend_and_pack(px[0], px[1], px[2], px[3]));
			end
		end

		pixel_valid <= 1'b0;
		wait (pending_pixels.size() == 0);
		repeat (LAT_PAD) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
